FILE: rtl/stt_pkg.sv
// Shared constants, codes and helpers for the slotted timer table.
// No dependencies; imported by slotted_timer_table_core.
`default_nettype none
package stt_pkg;

	localparam int unsigned TIMER_SLOTS_DEF = 32;

	localparam int unsigned TIME_W  = 63;
	localparam int unsigned ID_W    = 32;
	localparam int unsigned IVL_W   = 40;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned POL_W   = 2;
	localparam int unsigned STAT_W  = 2;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

	localparam logic [POL_W-1:0] POL_ONCE = 2'd0;
	localparam logic [POL_W-1:0] POL_NOW  = 2'd1;
	localparam logic [POL_W-1:0] POL_BASE = 2'd2;

	localparam logic [STAT_W-1:0] ST_GOOD      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [IVL_W-1:0]  period;
		logic [TIME_W-1:0] deadline;
		logic [POL_W-1:0]  policy;
	} slot_rec_t;

	// saturate at the top of the time range
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		sat_add = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/slotted_timer_table_core.sv
// Timer slot table: add, modify, remove and tick over a memory of slots.
// Depends on stt_pkg.
`default_nettype none
// Each accepted beat runs one pass over all TIMER_SLOTS slots, one slot per cycle
// through the single read port of the slot memory, and the first result beat is offered
// from S_CLOSE once the pass is through, or after S_FRD and S_FLD on a tick that fires.
// A tick then gives one beat per due timer, each read through S_FRD and S_FLD from a
// buffer of fired ids, and a closing beat with last set. Every beat of an item carries
// the earliest active deadline after the whole item. The input stalls from acceptance
// until the closing beat is taken, so no new item is accepted before the last is done.
module slotted_timer_table_core
	import stt_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [OP_W-1:0]   opcode,
	input  wire logic [ID_W-1:0]   timer_key,
	input  wire logic [IVL_W-1:0]  interval_ticks,
	input  wire logic [TIME_W-1:0] base_time,
	input  wire logic              base_given,
	input  wire logic [POL_W-1:0]  policy,
	input  wire logic [TIME_W-1:0] now,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [STAT_W-1:0]      status,
	output logic [ID_W-1:0]        result_id,
	output logic                   fired,
	output logic [TIME_W-1:0]      soonest,
	output logic                   last
);

	localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
	localparam logic [CW-1:0] SLOT_CNT = CW'(TIMER_SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_FRD, S_FLD, S_FWAIT, S_CLOSE, S_CWAIT
	} state_t;

	state_t state_q;

	// latched item
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   key_q;
	logic [IVL_W-1:0]  ivl_q;
	logic [TIME_W-1:0] origin_q;
	logic [POL_W-1:0]  pol_q;
	logic [TIME_W-1:0] now_q;

	slot_rec_t         slot_mem [TIMER_SLOTS];
	logic [ID_W-1:0]   fire_mem [TIMER_SLOTS];

	logic [TIMER_SLOTS-1:0] active_q;
	logic [ID_W-1:0]   id_ctr_q;
	logic [CW-1:0]     rd_cnt_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	slot_rec_t         rec_s1;
	logic              found_q;
	logic [TIME_W-1:0] soon_q;
	logic [CW-1:0]     nfired_q;
	logic [CW-1:0]     emit_q;
	logic [ID_W-1:0]   fire_rd_q;

	logic              out_vld_q;
	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0]   result_id_q;
	logic              fired_q;
	logic              last_q;

	// per-slot processing
	logic              act, hit, due;
	logic [TIME_W-1:0] add_a, add_b, sum;
	logic              wr_en, fire_push, found_set, act_set, act_clr;
	slot_rec_t         wr_rec;
	logic              new_act;
	logic [TIME_W-1:0] new_dl;
	logic [ID_W-1:0]   next_id;
	logic              scan_rd;
	logic              out_take;

	assign in_stall  = (state_q != S_IDLE);
	assign out_take  = out_vld_q && !out_stall;
	assign scan_rd   = (state_q == S_SCAN) && (rd_cnt_q < SLOT_CNT);
	assign next_id   = id_ctr_q + ID_W'(1);

	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign result_id = result_id_q;
	assign fired     = fired_q;
	assign soonest   = soon_q;
	assign last      = last_q;

	always_comb begin
		act       = active_q[idx_s1];
		hit       = act && (rec_s1.id == key_q);
		due       = act && (rec_s1.deadline <= now_q);
		add_a     = origin_q;
		add_b     = TIME_W'(ivl_q);
		wr_en     = 1'b0;
		fire_push = 1'b0;
		found_set = 1'b0;
		act_set   = 1'b0;
		act_clr   = 1'b0;
		wr_rec    = rec_s1;
		unique case (op_q)
			OP_ADD: begin
				if (!act && !found_q) begin
					wr_en     = 1'b1;
					found_set = 1'b1;
					act_set   = 1'b1;
					wr_rec.id = next_id;
				end
			end
			OP_MODIFY: begin
				if (hit && !found_q) begin
					wr_en     = 1'b1;
					found_set = 1'b1;
					wr_rec.id = rec_s1.id;
				end
			end
			OP_REMOVE: begin
				act_clr = hit;
			end
			default: begin
				if (due) begin
					fire_push = 1'b1;
					add_b     = TIME_W'(rec_s1.period);
					case (rec_s1.policy)
						POL_ONCE: act_clr = 1'b1;
						POL_NOW:  add_a = now_q;
						default:  add_a = rec_s1.deadline;
					endcase
					wr_en = (rec_s1.policy != POL_ONCE);
				end
			end
		endcase
		sum = sat_add(add_a, add_b);
		if (op_q != OP_TICK) begin
			wr_rec.period = ivl_q;
			wr_rec.policy = pol_q;
		end
		wr_rec.deadline = sum;
		wr_en   = wr_en && vld_s1;
		new_act = (act || act_set) && !act_clr;
		new_dl  = wr_en ? sum : rec_s1.deadline;
	end

	always_ff @(posedge clk) begin
		if (scan_rd) begin
			rec_s1 <= slot_mem[rd_cnt_q[IW-1:0]];
		end
		if (wr_en) begin
			slot_mem[idx_s1] <= wr_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && fire_push) begin
			fire_mem[nfired_q[IW-1:0]] <= rec_s1.id;
		end
		if (state_q == S_FRD) begin
			fire_rd_q <= fire_mem[emit_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q     <= opcode;
			key_q    <= timer_key;
			ivl_q    <= interval_ticks;
			origin_q <= base_given ? base_time : now;
			pol_q    <= policy;
			now_q    <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			id_ctr_q    <= '0;
			rd_cnt_q    <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			soon_q      <= TIME_MAX;
			nfired_q    <= '0;
			emit_q      <= '0;
			out_vld_q   <= 1'b0;
			status_q    <= ST_GOOD;
			result_id_q <= '0;
			fired_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			vld_s1 <= scan_rd;
			if (scan_rd) begin
				idx_s1   <= rd_cnt_q[IW-1:0];
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q  <= S_SCAN;
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						soon_q   <= TIME_MAX;
						nfired_q <= '0;
						emit_q   <= '0;
					end
				end
				S_SCAN: begin
					if (vld_s1) begin
						// apply slot update and fold into the running minimum
						active_q[idx_s1] <= new_act;
						if (found_set) begin
							found_q <= 1'b1;
						end
						if (found_set && op_q == OP_ADD) begin
							id_ctr_q <= next_id;
						end
						if (fire_push) begin
							nfired_q <= nfired_q + CW'(1);
						end
						if (new_act && new_dl < soon_q) begin
							soon_q <= new_dl;
						end
						if (idx_s1 == LAST_IDX) begin
							if (op_q == OP_TICK && (fire_push || nfired_q != '0)) begin
								state_q <= S_FRD;
							end else begin
								state_q <= S_CLOSE;
							end
						end
					end
				end
				S_FRD: begin
					state_q <= S_FLD;
				end
				S_FLD: begin
					out_vld_q   <= 1'b1;
					status_q    <= ST_GOOD;
					result_id_q <= fire_rd_q;
					fired_q     <= 1'b1;
					last_q      <= 1'b0;
					emit_q      <= emit_q + CW'(1);
					state_q     <= S_FWAIT;
				end
				S_FWAIT: begin
					if (out_take) begin
						out_vld_q <= 1'b0;
						state_q   <= (emit_q < nfired_q) ? S_FRD : S_CLOSE;
					end
				end
				S_CLOSE: begin
					out_vld_q   <= 1'b1;
					fired_q     <= 1'b0;
					last_q      <= 1'b1;
					result_id_q <= '0;
					unique case (op_q)
						OP_ADD: begin
							status_q <= found_q ? ST_GOOD : ST_FULL;
							if (found_q) begin
								result_id_q <= id_ctr_q;
							end
						end
						OP_MODIFY: status_q <= found_q ? ST_GOOD : ST_NOT_FOUND;
						default:   status_q <= ST_GOOD;
					endcase
					state_q <= S_CWAIT;
				end
				S_CWAIT: begin
					if (out_take) begin
						out_vld_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_vld_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (state_q == S_FWAIT || state_q == S_CWAIT))
		else $error("result beat offered outside an emit state");

	a_fire_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		nfired_q <= SLOT_CNT && emit_q <= nfired_q)
		else $error("fired count out of range");

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && fired_q) |-> !last_q)
		else $error("fired beat marked last");

	a_fire_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && op_q != OP_TICK) |=> $stable(nfired_q))
		else $error("fired id pushed outside a tick");

	a_scan_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> !out_vld_q)
		else $error("slot processed while a result is pending");

endmodule
`default_nettype wire
